### sv/serial_frame_deframer_assert.svh
// Assertion macros for the serial frame deframer.
`ifndef SERIAL_FRAME_DEFRAMER_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define SFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/sfd_pkg.sv
`timescale 1ns / 1ps
package sfd_pkg;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // Configuration register indexes
    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Parser phases
    typedef enum logic [3:0] {
        PH_SYNC0 = 4'd0,
        PH_SYNC1 = 4'd1,
        PH_ADDR  = 4'd2,
        PH_CMD   = 4'd3,
        PH_OFFL  = 4'd4,
        PH_OFFH  = 4'd5,
        PH_LENL  = 4'd6,
        PH_LENH  = 4'd7,
        PH_DATA  = 4'd8,
        PH_CSUM  = 4'd9
    } t_phase;

    // One result item
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  device_address;
        logic [7:0]  command_code;
        logic [15:0] frame_offset;
        logic [15:0] payload_length;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        logic        checksum_ok;
        logic        last_of_frame;
    } t_result;

    // Queue status seen by the top level
    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [QueueCntW-1:0] count;
    } t_q_status;

endpackage

### sv/sfd_front.sv
`timescale 1ns / 1ps
module sfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    output logic             o_res_valid,
    output sfd_pkg::t_result o_res
);
    import sfd_pkg::*;

    logic [7:0]  r_sync_first;
    logic [7:0]  r_sync_second;
    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_address;
    logic [7:0]  r_command;
    logic [15:0] r_offset;
    logic [15:0] r_length;
    logic [15:0] r_seen;
    logic [7:0]  r_sum;
    logic [15:0] n_seen;
    logic [7:0]  n_sum;

    assign n_seen = r_seen + 16'd1;
    assign n_sum  = r_sum + i_rx_byte;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= '0;
            r_sync_second <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SYNC1: begin
                if (i_rx_byte == r_sync_second) n_phase = PH_ADDR;
                else if (i_rx_byte == r_sync_first) n_phase = PH_SYNC1;
                else n_phase = PH_SYNC0;
            end
            PH_ADDR: n_phase = PH_CMD;
            PH_CMD:  n_phase = PH_OFFL;
            PH_OFFL: n_phase = PH_OFFH;
            PH_OFFH: n_phase = PH_LENL;
            PH_LENL: n_phase = PH_LENH;
            PH_LENH: begin
                n_phase = ({i_rx_byte, r_length[7:0]} == 16'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: n_phase = (n_seen >= r_length) ? PH_CSUM : PH_DATA;
            PH_CSUM: n_phase = PH_SYNC0;
            default: n_phase = (i_rx_byte == r_sync_first) ? PH_SYNC1 : PH_SYNC0;
        endcase
    end

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC0;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    // Header fields, payload count and running sum
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            unique case (r_phase)
                PH_ADDR: begin
                    r_address <= i_rx_byte;
                    r_sum     <= i_rx_byte;
                end
                PH_CMD: begin
                    r_command <= i_rx_byte;
                    r_sum     <= n_sum;
                end
                PH_OFFL: begin
                    r_offset <= {8'd0, i_rx_byte};
                    r_sum    <= n_sum;
                end
                PH_OFFH: begin
                    r_offset[15:8] <= i_rx_byte;
                    r_sum          <= n_sum;
                end
                PH_LENL: begin
                    r_length <= {8'd0, i_rx_byte};
                    r_sum    <= n_sum;
                end
                PH_LENH: begin
                    r_length[15:8] <= i_rx_byte;
                    r_sum          <= n_sum;
                    r_seen         <= '0;
                end
                PH_DATA: begin
                    r_sum  <= n_sum;
                    r_seen <= n_seen;
                end
                default: ;
            endcase
        end
    end

    // Result for the byte on the input
    always_comb begin
        o_res_valid          = 1'b0;
        o_res.item_kind      = KIND_PAYLOAD;
        o_res.device_address = r_address;
        o_res.command_code   = r_command;
        o_res.frame_offset   = r_offset;
        o_res.payload_length = r_length;
        o_res.payload_index  = r_seen;
        o_res.payload_byte   = i_rx_byte;
        o_res.checksum_ok    = 1'b0;
        o_res.last_of_frame  = 1'b0;
        unique case (r_phase)
            PH_DATA: o_res_valid = i_accept;
            PH_CSUM: begin
                o_res_valid         = i_accept;
                o_res.item_kind     = KIND_STATUS;
                o_res.payload_index = '0;
                o_res.payload_byte  = '0;
                o_res.checksum_ok   = (r_sum == i_rx_byte);
                o_res.last_of_frame = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

### sv/sfd_queue.sv
`timescale 1ns / 1ps
module sfd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sfd_pkg::t_result   i_data,
    input  logic               i_pop,
    output sfd_pkg::t_result   o_data,
    output sfd_pkg::t_q_status o_status
);
    import sfd_pkg::*;

    t_result                r_mem [QueueDepth];
    logic [QueuePtrW-1:0]   r_wr_ptr;
    logic [QueuePtrW-1:0]   r_rd_ptr;
    logic [QueueCntW-1:0]   r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QueueCntW'(QueueDepth));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

### sv/sfd_back.sv
`timescale 1ns / 1ps
module sfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  sfd_pkg::t_result i_data,
    output logic             o_take,
    input  logic             i_stall,
    output logic             o_valid,
    output sfd_pkg::t_result o_data
);
    import sfd_pkg::*;

    logic    r_valid;
    t_result r_data;

    // Load whenever the output register is empty or being drained
    assign o_take  = i_avail && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_avail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data <= i_data;
        end
    end

endmodule

### sv/serial_frame_deframer.sv
`timescale 1ns / 1ps
// Byte-serial frame parser. Bytes are taken one per clock unless o_in_stall
// is high (queue full): the parser hunts for the two sync bytes set through
// the configuration port, reads the six-byte header, then gives one payload
// result per payload byte and one end-of-frame status (with checksum_ok) for
// the checksum byte; sync and header bytes give nothing. Results pass
// through a four-entry queue and an output register, and the input keeps
// accepting while the output is stalled until the queue fills. Frames with a
// bad checksum are delivered whole and marked by checksum_ok low on the
// status result.
`include "serial_frame_deframer_assert.svh"
module serial_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_item_kind,
    output logic [7:0]  o_device_address,
    output logic [7:0]  o_command_code,
    output logic [15:0] o_frame_offset,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_payload_index,
    output logic [7:0]  o_payload_byte,
    output logic        o_checksum_ok,
    output logic        o_last_of_frame
);
    import sfd_pkg::*;

    logic      in_accept;
    logic      res_valid;
    t_result   res;
    t_result   q_data;
    t_q_status q_status;
    logic      q_pop;
    t_result   out_data;

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Front: sync hunt and header parse
    sfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Decoupling queue
    sfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_valid),
        .i_data   (res),
        .i_pop    (q_pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    // Back: output register
    sfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!q_status.empty),
        .i_data  (q_data),
        .o_take  (q_pop),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_data)
    );

    assign o_item_kind      = out_data.item_kind;
    assign o_device_address = out_data.device_address;
    assign o_command_code   = out_data.command_code;
    assign o_frame_offset   = out_data.frame_offset;
    assign o_payload_length = out_data.payload_length;
    assign o_payload_index  = out_data.payload_index;
    assign o_payload_byte   = out_data.payload_byte;
    assign o_checksum_ok    = out_data.checksum_ok;
    assign o_last_of_frame  = out_data.last_of_frame;

    // Checks
    `SFD_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n, !q_status.empty && !i_out_stall, o_out_valid)
    `SFD_ASSERT_IMPL(a_status_is_last, i_clk, i_rst_n, o_out_valid, o_last_of_frame == o_item_kind)
    `SFD_ASSERT_IMPL(a_payload_no_ok, i_clk, i_rst_n, o_out_valid && !o_item_kind, !o_checksum_ok)
    `SFD_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, q_status.count <= QueueCntW'(QueueDepth))

endmodule
